>>> hdl/rgwc_pkg.sv
// rgwc_pkg: shared types and constants of the rtt gradient window controller
// no dependencies; imported by rgwc_ctrl, rgwc_dp and the top level
`default_nettype none

package rgwc_pkg;

    // default depth of the rtt sample ring
    localparam int unsigned WINDOW_DEF = 8;

    // field widths
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned RTT_W    = 16;
    localparam int unsigned CWND_W   = 24;
    localparam int unsigned PKT_W    = 16;
    localparam int unsigned STEP_W   = 8;
    localparam int unsigned FACTOR_W = 9;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned CFG_W    = 9;
    localparam int unsigned IDX_W    = 2;

    // constants of the update rule
    localparam logic [RTT_W-1:0]  RTT_MAX    = '1;
    localparam logic [CWND_W-1:0] CWND_MAX   = '1;
    localparam logic [CWND_W-1:0] CWND_RESET = 24'd256;
    localparam logic [CWND_W:0]   ONE_PACKET = 25'd256;
    localparam logic [7:0]        PCT_SCALE  = 8'd100;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_INCREASE_STEP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_DECREASE_FACTOR = 2'd1;
    localparam logic [IDX_W-1:0] REG_STABLE_PERCENT  = 2'd2;

    // configuration reset values
    localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd59;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 9'd192;
    localparam logic [PCT_W-1:0]    PCT_RESET    = 7'd3;

    // window action codes
    typedef enum logic [1:0] {
        ACT_HOLD    = 2'd0,
        ACT_INC     = 2'd1,
        ACT_BACKOFF = 2'd2,
        ACT_FIRST   = 2'd3
    } t_action;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_READ,
        ST_DRAIN,
        ST_STABLE,
        ST_UPDATE,
        ST_LOAD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic sample;
        logic read;
        logic stable;
        logic update;
        logic load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last_read;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/rgwc_ctrl.sv
// rgwc_ctrl: sequencing state machine of the window controller
// depends on rgwc_pkg; drives the command struct of rgwc_dp
`default_nettype none

module rgwc_ctrl
    import rgwc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SAMPLE;
            end
            ST_SAMPLE: n_state = ST_READ;
            ST_READ: begin
                if (i_sts.last_read) n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = ST_STABLE;
            ST_STABLE: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_LOAD;
            ST_LOAD: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_SAMPLE: o_cmd.sample = 1'b1;
            ST_READ:   o_cmd.read   = 1'b1;
            ST_DRAIN:  o_cmd        = '0;
            ST_STABLE: o_cmd.stable = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_LOAD:   o_cmd.load   = i_sts.out_free;
            default:   o_cmd        = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/rgwc_dp.sv
// rgwc_dp: datapath of the window controller: rtt ring, minimum scan,
// stability test, window update and result register; depends on rgwc_pkg
`default_nettype none

module rgwc_dp
    import rgwc_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic [SEQ_W-1:0]    i_acked_sequence,
    input  wire logic [TIME_W-1:0]   i_send_time_ms,
    input  wire logic [TIME_W-1:0]   i_ack_time_ms,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [PKT_W-1:0]         o_window_packets,
    output logic [RTT_W-1:0]         o_min_rtt_ms,
    output logic [1:0]               o_window_action
);

    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FW = $clog2(WINDOW + 1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW);

    // configuration registers
    logic [STEP_W-1:0]   r_step;
    logic [FACTOR_W-1:0] r_factor;
    logic [PCT_W-1:0]    r_pct;

    // per request state
    logic [RTT_W-1:0]  r_rtt;
    logic              r_first;
    logic [RTT_W-1:0]  r_ring [WINDOW];
    logic [RTT_W-1:0]  r_rd_data;
    logic              r_cmp_vld;
    logic [FW-1:0]     r_k;
    logic [RTT_W-1:0]  r_best;
    logic              r_stable;

    // persistent state
    logic [FW-1:0]     r_fill;
    logic [AW-1:0]     r_slot;
    logic [RTT_W-1:0]  r_prev;
    logic [CWND_W-1:0] r_cwnd;
    logic              r_grew;
    t_action           r_act;

    // result register
    logic              r_out_valid;
    logic [PKT_W-1:0]  r_out_pkts;
    logic [RTT_W-1:0]  r_out_min;
    t_action           r_out_act;

    logic [TIME_W:0]        n_diff;
    logic [RTT_W-1:0]       n_rtt;
    logic signed [RTT_W:0]  n_delta;
    logic signed [24:0]     n_lhs;
    logic signed [24:0]     n_rhs;
    logic                   n_stable;
    logic [CWND_W+FACTOR_W-1:0] n_prod;
    logic [CWND_W:0]        n_sum;
    logic [CWND_W:0]        n_wide;
    t_action                n_act;
    logic [CWND_W-1:0]      n_cwnd;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_RESET;
            r_factor <= FACTOR_RESET;
            r_pct    <= PCT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INCREASE_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                REG_DECREASE_FACTOR: r_factor <= i_cfg_data;
                REG_STABLE_PERCENT:  r_pct    <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // rtt of the incoming ack, saturated; ack before send also saturates
    always_comb begin
        n_diff = {1'b0, i_ack_time_ms} - {1'b0, i_send_time_ms};
        if (n_diff[TIME_W] || (n_diff[TIME_W-1:0] > TIME_W'(RTT_MAX))) begin
            n_rtt = RTT_MAX;
        end else begin
            n_rtt = n_diff[RTT_W-1:0];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rtt   <= n_rtt;
            r_first <= (i_acked_sequence == '0);
        end
    end

    // sample ring write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            r_ring[r_slot] <= r_rtt;
        end
    end

    // sample ring read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[r_k[AW-1:0]];
    end

    // fill count and write slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_slot <= '0;
        end else if (i_cmd.sample) begin
            if (r_fill != FILL_FULL) r_fill <= r_fill + FW'(1);
            r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + AW'(1);
        end
    end

    // minimum scan over stored samples, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            r_k    <= '0;
            r_best <= RTT_MAX;
        end else begin
            if (i_cmd.read) r_k <= r_k + FW'(1);
            if (r_cmp_vld && (r_rd_data < r_best)) r_best <= r_rd_data;
        end
    end

    assign o_sts.last_read = (FW'(r_k + FW'(1)) == r_fill);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // stability test: 100*(min-prev) < pct*prev, prev non-zero
    always_comb begin
        n_delta  = $signed({1'b0, r_best}) - $signed({1'b0, r_prev});
        n_lhs    = 25'(n_delta * $signed({1'b0, PCT_SCALE}));
        n_rhs    = $signed({2'b00, 23'(r_pct * r_prev)});
        n_stable = (r_prev != '0) && (n_lhs < n_rhs);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stable) r_stable <= n_stable;
    end

    // window update
    always_comb begin
        n_prod = r_cwnd * r_factor;
        n_sum  = {1'b0, r_cwnd};
        n_act  = ACT_HOLD;
        if (r_first) begin
            n_sum = {1'b0, r_cwnd} + ONE_PACKET;
            n_act = ACT_FIRST;
        end else if (r_stable) begin
            n_sum = {1'b0, r_cwnd} + (CWND_W+1)'(r_step);
            n_act = ACT_INC;
        end else if (r_grew) begin
            n_act = ACT_BACKOFF;
        end
        n_wide = (n_act == ACT_BACKOFF) ? n_prod[CWND_W+FACTOR_W-1:8] : n_sum;
        n_cwnd = n_wide[CWND_W] ? CWND_MAX : n_wide[CWND_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cwnd <= CWND_RESET;
            r_grew <= 1'b0;
        end else if (i_cmd.update) begin
            r_prev <= r_best;
            r_cwnd <= n_cwnd;
            r_grew <= (n_cwnd > r_cwnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) r_act <= n_act;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_pkts <= (r_cwnd[CWND_W-1:8] == '0) ? PKT_W'(1) : r_cwnd[CWND_W-1:8];
            r_out_min  <= r_prev;
            r_out_act  <= r_act;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_window_packets = r_out_pkts;
    assign o_min_rtt_ms     = r_out_min;
    assign o_window_action  = r_out_act;

endmodule

`default_nettype wire

>>> hdl/rtt_gradient_window_controller.sv
// rtt_gradient_window_controller: a request passes capture, ring write, ring scan,
// drain, stability test, window update and result load in that order; the one-port
// ring scan reads one stored sample a cycle; one request is in work at a time, so
// a new request is accepted only after the previous result has been loaded.
// synchronous active-low reset: window one packet, ring empty, registers default
// depends on rgwc_pkg, rgwc_ctrl and rgwc_dp
`default_nettype none

module rtt_gradient_window_controller
    import rgwc_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [SEQ_W-1:0]   i_acked_sequence,
    input  wire logic [TIME_W-1:0]  i_send_time_ms,
    input  wire logic [TIME_W-1:0]  i_ack_time_ms,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [PKT_W-1:0]        o_window_packets,
    output logic [RTT_W-1:0]        o_min_rtt_ms,
    output logic [1:0]              o_window_action
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    rgwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    rgwc_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_acked_sequence (i_acked_sequence),
        .i_send_time_ms   (i_send_time_ms),
        .i_ack_time_ms    (i_ack_time_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_window_packets (o_window_packets),
        .o_min_rtt_ms     (o_min_rtt_ms),
        .o_window_action  (o_window_action)
    );

`ifndef NO_ASSERTIONS
    // at most one datapath command a cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.sample, cmd.read, cmd.stable, cmd.update, cmd.load}))
        else $error("more than one datapath command");

    // an accepted request is written into the ring next cycle
    a_accept_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> cmd.sample)
        else $error("accepted request not sampled");

    // a result load always shows up as a valid result
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_out_valid)
        else $error("loaded result not valid");

    // the scan stops after the last stored sample
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.read && sts.last_read) |=> !cmd.read)
        else $error("scan ran past the fill count");
`endif

endmodule

`default_nettype wire
